[rtl/fxmd_pkg.sv]
// Shared types and constants for the 16.16 fixed-point multiply/divide unit.
// Used by every module under rtl/; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fxmd_pkg;

  // Operation codes carried in the kind field
  localparam logic KIND_MUL = 1'b0;
  localparam logic KIND_DIV = 1'b1;

  // Number of fraction bits and the overflow guard shift
  localparam int FRAC_BITS   = 16;
  localparam int GUARD_SHIFT = 14;

  // Quotient bits produced by the divider, one per pipeline step
  localparam int QUO_BITS = 30;

  // Saturation values
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;
  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;

  // Pipeline latency from accepted transaction to result strobe
  localparam int LATENCY = QUO_BITS + 3;

  // Input transaction
  typedef struct packed {
    logic               kind;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } fxmd_in_t;

  // Result transaction
  typedef struct packed {
    logic signed [31:0] result;
    logic               saturated;
  } fxmd_out_t;

  // Per-stage pipeline word
  typedef struct packed {
    logic                vld;
    logic                kind;
    logic                neg;
    logic                sat;
    logic [31:0]         mb;
    logic [31:0]         rem;
    logic [QUO_BITS-1:0] dnd;
    logic [QUO_BITS-1:0] quo;
    logic [31:0]         mul;
  } fxmd_pipe_t;

endpackage

`default_nettype wire

[rtl/fxmd_front.sv]
// Front end: operand register with magnitudes, then multiply and divide guard.
// Depends on fxmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fxmd_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_vld,
  input  fxmd_pkg::fxmd_in_t   in_data,
  output fxmd_pkg::fxmd_pipe_t pipe_o
);
  import fxmd_pkg::*;

  logic               a_vld_r;
  logic               a_kind_r;
  logic signed [31:0] a_a_r;
  logic signed [31:0] a_b_r;
  logic [31:0]        a_ma_r;
  logic [31:0]        a_mb_r;

  logic [31:0]        a_u;
  logic [31:0]        b_u;
  logic [31:0]        ma_nxt;
  logic [31:0]        mb_nxt;

  logic signed [63:0] prod;
  logic [31:0]        ma_hi;
  fxmd_pipe_t         pipe_nxt;
  fxmd_pipe_t         pipe_r;

  // Take 32-bit magnitudes; the most negative value maps to 2^31 unsigned
  assign a_u    = in_data.a;
  assign b_u    = in_data.b;
  assign ma_nxt = a_u[31] ? (~a_u + 32'd1) : a_u;
  assign mb_nxt = b_u[31] ? (~b_u + 32'd1) : b_u;

  // Register operands and magnitudes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
    end
    a_kind_r <= in_data.kind;
    a_a_r    <= in_data.a;
    a_b_r    <= in_data.b;
    a_ma_r   <= ma_nxt;
    a_mb_r   <= mb_nxt;
  end

  // Form the product and the first partial remainder of the divide
  assign prod  = a_a_r * a_b_r;
  assign ma_hi = {{GUARD_SHIFT{1'b0}}, a_ma_r[31:GUARD_SHIFT]};

  always_comb begin
    pipe_nxt      = '0;
    pipe_nxt.vld  = a_vld_r;
    pipe_nxt.kind = a_kind_r;
    pipe_nxt.neg  = a_a_r[31] ^ a_b_r[31];
    // Guard trips when the quotient would not fit, including a zero divisor
    pipe_nxt.sat  = (a_kind_r == KIND_DIV) && (ma_hi >= a_mb_r);
    pipe_nxt.mb   = a_mb_r;
    pipe_nxt.rem  = ma_hi;
    pipe_nxt.dnd  = {a_ma_r[GUARD_SHIFT-1:0], {FRAC_BITS{1'b0}}};
    pipe_nxt.quo  = '0;
    pipe_nxt.mul  = prod[FRAC_BITS+31:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r.vld <= 1'b0;
    end else begin
      pipe_r <= pipe_nxt;
    end
  end

  assign pipe_o = pipe_r;

endmodule

`default_nettype wire

[rtl/fxmd_div_step.sv]
// One registered restoring-divide step: yields one quotient bit per stage.
// Depends on fxmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fxmd_div_step (
  input  wire                  clk,
  input  wire                  rst_n,
  input  fxmd_pkg::fxmd_pipe_t pipe_i,
  output fxmd_pkg::fxmd_pipe_t pipe_o
);
  import fxmd_pkg::*;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;
  fxmd_pipe_t  pipe_nxt;
  fxmd_pipe_t  pipe_r;

  // Shift in the next dividend bit and try to subtract the divisor
  assign trial = {pipe_i.rem, pipe_i.dnd[QUO_BITS-1]};
  assign diff  = trial - {1'b0, pipe_i.mb};
  assign ge    = (trial >= {1'b0, pipe_i.mb});

  always_comb begin
    pipe_nxt     = pipe_i;
    pipe_nxt.rem = ge ? diff[31:0] : trial[31:0];
    pipe_nxt.dnd = {pipe_i.dnd[QUO_BITS-2:0], 1'b0};
    pipe_nxt.quo = {pipe_i.quo[QUO_BITS-2:0], ge};
  end

  // Advance the stage; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r.vld <= 1'b0;
    end else begin
      pipe_r <= pipe_nxt;
    end
  end

  assign pipe_o = pipe_r;

endmodule

`default_nettype wire

[rtl/fixed_16_16_mul_div.sv]
// Top level of the signed 16.16 fixed-point multiply/divide unit.
// Depends on fxmd_pkg, fxmd_front and fxmd_div_step.
//
// A transaction is taken on every cycle with start high (busy is always
// low), and its result appears on out_data with out_valid high exactly 33
// cycles later, in order, for one cycle: the receiver must take it then.
// The latency is set by the 30-stage restoring divider, one quotient bit per
// stage, plus the operand stage, the multiply/guard stage and the output
// register; multiplies travel the same pipeline so order is kept.
`timescale 1ns / 1ps
`default_nettype none

module fixed_16_16_mul_div (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  fxmd_pkg::fxmd_in_t  in_data,
  output logic                out_valid,
  output fxmd_pkg::fxmd_out_t out_data
);
  import fxmd_pkg::*;

  fxmd_pipe_t  pipe [QUO_BITS+1];
  fxmd_pipe_t  last;
  logic        out_valid_r;
  fxmd_out_t   out_data_r;
  fxmd_out_t   out_data_nxt;
  logic [31:0] quo_ext;

  // Fully pipelined: never holds off a transaction
  assign busy = 1'b0;

  fxmd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start),
    .in_data (in_data),
    .pipe_o  (pipe[0])
  );

  // Chain of divide steps
  for (genvar i = 0; i < QUO_BITS; i++) begin : g_step
    fxmd_div_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .pipe_i (pipe[i]),
      .pipe_o (pipe[i+1])
    );
  end

  assign last    = pipe[QUO_BITS];
  assign quo_ext = {{(32-QUO_BITS){1'b0}}, last.quo};

  // Select product, clamp value or signed quotient
  always_comb begin
    out_data_nxt = '0;
    if (last.kind == KIND_MUL) begin
      out_data_nxt.result    = last.mul;
      out_data_nxt.saturated = 1'b0;
    end else if (last.sat) begin
      out_data_nxt.result    = last.neg ? SAT_NEG : SAT_POS;
      out_data_nxt.saturated = 1'b1;
    end else begin
      out_data_nxt.result    = last.neg ? (~quo_ext + 32'd1) : quo_ext;
      out_data_nxt.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last.vld;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // Every accepted transaction yields exactly one result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(start && !busy && rst_n, LATENCY))
    else $error("result strobe does not match accepted transaction");

  // A clamped result carries one of the two saturation values
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.result == SAT_NEG || out_data.result == SAT_POS))
    else $error("saturated result with wrong value");

  // Restoring divide leaves a remainder below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (last.vld && last.kind == KIND_DIV && !last.sat) |-> (last.rem < last.mb))
    else $error("divide remainder out of range");

  // Saturation is only reported for divides
  a_sat_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (last.vld && last.kind == KIND_MUL) |=> !out_data.saturated)
    else $error("multiply reported saturation");
`endif

endmodule

`default_nettype wire

[tb/fixed_16_16_mul_div_tb.sv]
// Self-checking testbench for the signed 16.16 fixed-point multiply/divide unit.
// Depends on fxmd_pkg and fixed_16_16_mul_div; predicts each result in place and
// checks every strobed result in order against the oldest pending prediction.
`timescale 1ns / 1ps

module fixed_16_16_mul_div_tb;

  import fxmd_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int RANDOM_ITEMS = 950;
  localparam int SEGMENT_LEN  = 60;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  fxmd_in_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  fxmd_out_t out_data;

  fxmd_out_t pending_results[$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        max_gap = 0;

  fixed_16_16_mul_div dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Compute the 16.16 product or guarded quotient of one transaction
  function automatic fxmd_out_t fixed_point_result(fxmd_in_t t);
    logic [63:0] product;
    logic [32:0] mag_a;
    logic [32:0] mag_b;
    logic [48:0] quotient;
    logic        negate;
    fxmd_out_t   r;
    r = '0;
    if (t.kind == KIND_MUL) begin
      product = {{32{t.a[31]}}, t.a} * {{32{t.b[31]}}, t.b};
      r.result = product[47:16];
    end else begin
      // magnitudes in 33 bits so that the most negative value keeps its size
      mag_a = t.a[31] ? 33'h1_0000_0000 - {1'b0, t.a} : {1'b0, t.a};
      mag_b = t.b[31] ? 33'h1_0000_0000 - {1'b0, t.b} : {1'b0, t.b};
      negate = t.a[31] ^ t.b[31];
      if ((mag_a >> GUARD_SHIFT) >= mag_b) begin
        r.result = negate ? SAT_NEG : SAT_POS;
        r.saturated = 1'b1;
      end else begin
        quotient = (49'(mag_a) << FRAC_BITS) / 49'(mag_b);
        if (negate) quotient = -quotient;
        r.result = quotient[31:0];
      end
    end
    return r;
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    mismatches++;
  endtask

  // Predict on every accepted transaction, check every strobed result
  always @(posedge clk) begin
    fxmd_out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction pending", out_data.result, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.result !== want.result)
          report_mismatch("result", out_data.result, want.result);
        if (out_data.saturated !== want.saturated)
          report_mismatch("saturated", 32'(out_data.saturated), 32'(want.saturated));
      end
    end
    if (rst_n && start && !busy)
      pending_results.push_back(fixed_point_result(in_data));
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Hold off a random number of cycles, then present one transaction until taken
  task automatic send_operation(logic kind, logic [31:0] a, logic [31:0] b);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= '{kind: kind, a: a, b: b};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Draw an operand from a mix of full-range, extreme, small and integer values
  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1: return 32'($urandom_range(0, 32'h7_FFFF)) - 32'h4_0000;
      2: return {16'($urandom_range(0, 16'hFFFF)), 16'h0000};
      default: return $urandom;
    endcase
  endfunction

  // Pick a divisor at or next to the overflow guard threshold for dividend a
  function automatic logic [31:0] guard_divisor(logic [31:0] a);
    logic [32:0] mag_a;
    logic [32:0] edge_b;
    mag_a = a[31] ? 33'h1_0000_0000 - {1'b0, a} : {1'b0, a};
    edge_b = (mag_a >> GUARD_SHIFT) + 33'($urandom_range(0, 2)) - 33'd1;
    return $urandom_range(0, 1) ? -edge_b[31:0] : edge_b[31:0];
  endfunction

  // Multiply: zero, unity, extremes, wrap and sign handling
  task automatic test_mul_extremes();
    send_operation(KIND_MUL, 32'h0000_0000, 32'h0000_0000);
    send_operation(KIND_MUL, 32'h0001_0000, 32'h0001_0000);
    send_operation(KIND_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_operation(KIND_MUL, 32'h8000_0000, 32'h8000_0000);
    send_operation(KIND_MUL, 32'h8000_0000, 32'h7FFF_FFFF);
    send_operation(KIND_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
    send_operation(KIND_MUL, 32'hFFFE_8000, 32'h0002_4000);
  endtask

  // Divide: zero divisor, guard boundary, most negative operands, truncation
  task automatic test_div_guard_cases();
    send_operation(KIND_DIV, 32'h0003_0000, 32'h0000_0000);
    send_operation(KIND_DIV, 32'hFFFD_0000, 32'h0000_0000);
    send_operation(KIND_DIV, 32'h0000_0000, 32'h0000_0000);
    send_operation(KIND_DIV, 32'h8000_0000, 32'h8000_0000);
    send_operation(KIND_DIV, 32'h8000_0000, 32'h0000_0001);
    send_operation(KIND_DIV, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_operation(KIND_DIV, 32'h7FFF_FFFF, 32'h0000_0001);
    // exactly at the guard, then one above it
    send_operation(KIND_DIV, 32'h0100_0000, 32'h0000_0400);
    send_operation(KIND_DIV, 32'h0100_0000, 32'h0000_0401);
    send_operation(KIND_DIV, 32'h7FFF_FFFF, 32'h0002_0000);
    send_operation(KIND_DIV, 32'h0000_0001, 32'h7FFF_FFFF);
    send_operation(KIND_DIV, 32'h0000_0005, 32'h8000_0000);
    send_operation(KIND_DIV, 32'hFFFF_FFFF, 32'h0000_0003);
    send_operation(KIND_DIV, 32'h0007_0000, 32'hFFFE_0000);
  endtask

  // Random mix of operations, with idle gaps changing every segment
  task automatic test_random_traffic(int count);
    logic        kind;
    logic [31:0] a;
    logic [31:0] b;
    for (int i = 0; i < count; i++) begin
      if (i % SEGMENT_LEN == 0) begin
        case ($urandom_range(0, 2))
          0: max_gap = 0;
          1: max_gap = 3;
          default: max_gap = 15;
        endcase
      end
      kind = $urandom_range(0, 1) ? KIND_DIV : KIND_MUL;
      a = random_operand();
      if (kind == KIND_DIV && $urandom_range(0, 2) == 0)
        b = guard_divisor(a);
      else
        b = random_operand();
      send_operation(kind, a, b);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    max_gap = 2;
    test_mul_extremes();
    test_div_guard_cases();
    test_random_traffic(RANDOM_ITEMS);
    start <= 1'b0;
    // drain the pipeline, then watch for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
rtl/fxmd_pkg.sv
rtl/fxmd_front.sv
rtl/fxmd_div_step.sv
rtl/fixed_16_16_mul_div.sv
tb/fixed_16_16_mul_div_tb.sv
